@@ design/fmjd_pkg.sv @@
// Package for the filament motion jam detector.
// Holds the configuration and per-channel state types and the code constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fmjd_pkg;

  localparam int unsigned AdcW     = 12;
  localparam int unsigned StepW    = 32;
  localparam int unsigned DistW    = 24;
  localparam int unsigned HistW    = 8;
  localparam int unsigned DsCntW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Command codes of an input beat.
  localparam logic CMD_STEP   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ENABLE_MASK      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CHECK_STEPS      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD        = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DEAD_SPACE_HIGH  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DEAD_SPACE_LOW   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_HISTORY_LENGTH   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_DEAD_SPACE_LIMIT = 3'd6;

  localparam logic [DsCntW-1:0] DS_CNT_MAX = 8'hff;

  typedef struct packed {
    logic [1:0]        enable_mask;
    logic [DistW-1:0]  check_steps;
    logic [AdcW-1:0]   threshold;
    logic [AdcW-1:0]   dead_space_high;
    logic [AdcW-1:0]   dead_space_low;
    logic [3:0]        history_length;
    logic [DsCntW-1:0] dead_space_limit;
  } cfg_t;

  typedef struct packed {
    logic [StepW-1:0]  step_cnt;
    logic [AdcW-1:0]   start_lvl;
    logic [HistW-1:0]  err_hist;
    logic [DsCntW-1:0] ds_cnt;
    logic              trig;
  } chan_state_t;

  typedef struct packed {
    logic             cmd;
    logic             channel;
    logic             forward;
    logic [AdcW-1:0]  adc_value;
  } item_t;

endpackage

`default_nettype wire

@@ design/fmjd_eval.sv @@
// Per-item evaluation of one channel: step counting, level capture and the
// distance check with history and dead-space handling. Uses fmjd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fmjd_eval
  import fmjd_pkg::*;
(
  input  item_t       item_i,
  input  cfg_t        cfg_i,
  input  chan_state_t cur_i,
  output chan_state_t nxt_o,
  output logic        evaluated_o
);

  logic [AdcW-1:0]  diff;
  logic             err;
  logic [3:0]       hist_n;
  logic [HistW-1:0] mask;
  logic             start_dead;
  logic             adc_dead;
  logic [DsCntW-1:0] ds_inc;
  logic [HistW-1:0] hist_new;
  logic             due;

  always_comb begin
    diff = (item_i.adc_value >= cur_i.start_lvl) ? item_i.adc_value - cur_i.start_lvl
                                                 : cur_i.start_lvl - item_i.adc_value;
    err  = diff < cfg_i.threshold;

    hist_n = (cfg_i.history_length > 4'd8) ? 4'd8 : cfg_i.history_length;
    mask   = HistW'((9'd1 << hist_n) - 9'd1);

    start_dead = (cur_i.start_lvl > cfg_i.dead_space_high) ||
                 (cur_i.start_lvl < cfg_i.dead_space_low);
    adc_dead   = (item_i.adc_value > cfg_i.dead_space_high) ||
                 (item_i.adc_value < cfg_i.dead_space_low);
    ds_inc     = (cur_i.ds_cnt == DS_CNT_MAX) ? DS_CNT_MAX : cur_i.ds_cnt + 8'd1;

    // A negative counter never reaches the check distance.
    due = !cur_i.step_cnt[StepW-1] &&
          (cur_i.step_cnt >= {{(StepW-DistW){1'b0}}, cfg_i.check_steps});

    nxt_o       = cur_i;
    evaluated_o = 1'b0;
    hist_new    = cur_i.err_hist;

    if (item_i.cmd == CMD_STEP) begin
      nxt_o.step_cnt = item_i.forward ? cur_i.step_cnt + 32'd1 : cur_i.step_cnt - 32'd1;
    end else if (cfg_i.enable_mask[item_i.channel]) begin
      if (cur_i.start_lvl == '0) begin
        nxt_o.start_lvl = item_i.adc_value;
        nxt_o.step_cnt  = '0;
      end else if (due) begin
        evaluated_o = 1'b1;
        if (err && start_dead && adc_dead) begin
          if (ds_inc >= cfg_i.dead_space_limit) begin
            nxt_o.ds_cnt = '0;
            hist_new     = mask;
          end else begin
            nxt_o.ds_cnt = ds_inc;
            hist_new     = '0;
          end
        end else begin
          nxt_o.ds_cnt = '0;
          hist_new     = {cur_i.err_hist[HistW-2:0], err};
        end
        nxt_o.err_hist  = hist_new;
        nxt_o.trig      = (hist_new & mask) == mask;
        nxt_o.start_lvl = item_i.adc_value;
        nxt_o.step_cnt  = '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/filament_motion_jam_detector.sv @@
// Filament motion jam detector: takes one beat per cycle while in_stall_o is low; each input beat gives one result
// beat, through an input register and then a result register. The evaluation of
// a beat is one pass of fmjd_eval over its channel's state, so back-to-back beats on the same
// channel see each other's updates in order. Uses fmjd_pkg and fmjd_eval.
`timescale 1ns / 1ps
`default_nettype none

module filament_motion_jam_detector
  import fmjd_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration writes.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  // Input beats.
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                cmd_i,
  input  wire logic                channel_i,
  input  wire logic                forward_i,
  input  wire logic [AdcW-1:0]     adc_value_i,
  // Result beats.
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic                     out_channel_o,
  output logic                     evaluated_o,
  output logic                     jammed_o
);

  localparam int unsigned ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  cfg_t        cfg_q;
  chan_state_t state_q [CHANNELS];

  logic        s1_valid_q;
  item_t       s1_item_q;
  logic        s1_fire;
  logic        ch_ok;
  logic [ChIdxW-1:0] ch_idx;
  chan_state_t cur_state;
  chan_state_t nxt_state;
  logic        eval_done;

  logic        out_valid_q;
  logic        out_channel_q;
  logic        evaluated_q;
  logic        jammed_q;

  // Configuration register file.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable_mask      <= 2'd3;
      cfg_q.check_steps      <= 24'd1000;
      cfg_q.threshold        <= 12'd100;
      cfg_q.dead_space_high  <= 12'd4095;
      cfg_q.dead_space_low   <= 12'd0;
      cfg_q.history_length   <= 4'd3;
      cfg_q.dead_space_limit <= 8'd8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_ENABLE_MASK:      cfg_q.enable_mask      <= cfg_data_i[1:0];
        REG_CHECK_STEPS:      cfg_q.check_steps      <= cfg_data_i[DistW-1:0];
        REG_THRESHOLD:        cfg_q.threshold        <= cfg_data_i[AdcW-1:0];
        REG_DEAD_SPACE_HIGH:  cfg_q.dead_space_high  <= cfg_data_i[AdcW-1:0];
        REG_DEAD_SPACE_LOW:   cfg_q.dead_space_low   <= cfg_data_i[AdcW-1:0];
        REG_HISTORY_LENGTH:   cfg_q.history_length   <= cfg_data_i[3:0];
        REG_DEAD_SPACE_LIMIT: cfg_q.dead_space_limit <= cfg_data_i[DsCntW-1:0];
        default: ;
      endcase
    end
  end

  // The input register moves on whenever the result register is free or draining.
  assign s1_fire    = s1_valid_q && !(out_valid_q && out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_item_q.cmd       <= cmd_i;
      s1_item_q.channel   <= channel_i;
      s1_item_q.forward   <= forward_i;
      s1_item_q.adc_value <= adc_value_i;
    end
  end

  // A channel number beyond the configured count leaves all state alone.
  assign ch_ok     = (CHANNELS > 1) || (s1_item_q.channel == 1'b0);
  assign ch_idx    = ch_ok ? ChIdxW'(s1_item_q.channel) : '0;
  assign cur_state = state_q[ch_idx];

  fmjd_eval u_eval (
    .item_i      (s1_item_q),
    .cfg_i       (cfg_q),
    .cur_i       (cur_state),
    .nxt_o       (nxt_state),
    .evaluated_o (eval_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        state_q[i] <= '0;
      end
    end else if (s1_fire && ch_ok) begin
      state_q[ch_idx] <= nxt_state;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      out_channel_q <= s1_item_q.channel;
      evaluated_q   <= ch_ok && eval_done;
      jammed_q      <= ch_ok && nxt_state.trig;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign evaluated_o   = evaluated_q;
  assign jammed_o      = jammed_q;

endmodule

`default_nettype wire

@@ tb/sv/filament_motion_jam_detector_tb.sv @@
// Self-checking testbench for filament_motion_jam_detector: directed cases, then random step and
// sample traffic under several register settings, checked beat by beat against a local model.
// Depends on fmjd_pkg and the filament_motion_jam_detector RTL.
`timescale 1ns / 1ps

module filament_motion_jam_detector_tb;
  import fmjd_pkg::*;

  localparam int STUCK_LIMIT = 1000;
  localparam int MAX_PRINTED = 50;

  typedef struct packed {
    logic channel;
    logic evaluated;
    logic jammed;
  } verdict_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;
  logic                in_valid_i  = 1'b0;
  logic                cmd_i       = CMD_STEP;
  logic                channel_i   = 1'b0;
  logic                forward_i   = 1'b0;
  logic [AdcW-1:0]     adc_value_i = '0;
  logic                out_stall_i = 1'b0;
  logic                cfg_ready_o;
  logic                in_stall_o;
  logic                out_valid_o;
  logic                out_channel_o;
  logic                evaluated_o;
  logic                jammed_o;

  // Model of the block: register copy and per-channel state.
  cfg_t              cfg_shadow;
  logic [StepW-1:0]  step_count   [2];
  logic [AdcW-1:0]   base_level   [2];
  logic [HistW-1:0]  miss_history [2];
  logic [DsCntW-1:0] dead_hits    [2];
  logic              jam_flag     [2];

  verdict_t expected_verdicts[$];
  verdict_t want;
  item_t    seen_beat;

  bit no_idle      = 1'b0;
  int stall_left   = 0;
  int hold         = 0;
  int stuck_cycles = 0;
  int mismatches   = 0;
  int beats_taken  = 0;
  int results_seen = 0;
  int checks_seen  = 0;
  int jams_seen    = 0;

  filament_motion_jam_detector DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .cmd_i        (cmd_i),
    .channel_i    (channel_i),
    .forward_i    (forward_i),
    .adc_value_i  (adc_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_channel_o(out_channel_o),
    .evaluated_o  (evaluated_o),
    .jammed_o     (jammed_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic int next_wait();
    return no_idle ? 0 : int'($urandom_range(0, 9));
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void reset_predictor();
    cfg_shadow.enable_mask      = 2'd3;
    cfg_shadow.check_steps      = 24'd1000;
    cfg_shadow.threshold        = 12'd100;
    cfg_shadow.dead_space_high  = 12'd4095;
    cfg_shadow.dead_space_low   = 12'd0;
    cfg_shadow.history_length   = 4'd3;
    cfg_shadow.dead_space_limit = 8'd8;
    for (int c = 0; c < 2; c++) begin
      step_count[c]   = '0;
      base_level[c]   = '0;
      miss_history[c] = '0;
      dead_hits[c]    = '0;
      jam_flag[c]     = 1'b0;
    end
  endfunction

  function automatic bit in_dead_band(input logic [AdcW-1:0] lvl);
    return lvl > cfg_shadow.dead_space_high || lvl < cfg_shadow.dead_space_low;
  endfunction

  function automatic verdict_t predict_verdict(input item_t beat);
    verdict_t         v;
    int               c;
    int               n;
    int               delta;
    logic [HistW-1:0] hmask;
    bit               miss;
    c = int'(beat.channel);
    v.channel = beat.channel;
    v.evaluated = 1'b0;
    if (beat.cmd == CMD_STEP) begin
      step_count[c] = beat.forward ? step_count[c] + 32'd1 : step_count[c] - 32'd1;
    end else if (cfg_shadow.enable_mask[c]) begin
      if (base_level[c] == '0) begin
        // An unset level is only captured; the count restarts from here.
        base_level[c] = beat.adc_value;
        step_count[c] = '0;
      end else if (!step_count[c][StepW-1] &&
                   step_count[c] >= {8'd0, cfg_shadow.check_steps}) begin
        delta = int'(beat.adc_value) - int'(base_level[c]);
        if (delta < 0) delta = -delta;
        miss = delta < int'(cfg_shadow.threshold);
        n = (cfg_shadow.history_length > 4'd8) ? 8 : int'(cfg_shadow.history_length);
        hmask = HistW'((1 << n) - 1);
        if (miss && in_dead_band(base_level[c]) && in_dead_band(beat.adc_value)) begin
          if (dead_hits[c] != DS_CNT_MAX) dead_hits[c]++;
          if (dead_hits[c] >= cfg_shadow.dead_space_limit) begin
            dead_hits[c] = '0;
            miss_history[c] = hmask;
          end else begin
            miss_history[c] = '0;
          end
        end else begin
          dead_hits[c] = '0;
          miss_history[c] = {miss_history[c][HistW-2:0], miss};
        end
        jam_flag[c] = (miss_history[c] & hmask) == hmask;
        base_level[c] = beat.adc_value;
        step_count[c] = '0;
        v.evaluated = 1'b1;
      end
    end
    v.jammed = jam_flag[c];
    return v;
  endfunction

  // Monitor: tracks register writes, predicts each accepted input beat, checks each result beat
  // and drives the result-side stall.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      reset_predictor();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_ENABLE_MASK:      cfg_shadow.enable_mask      = cfg_data_i[1:0];
          REG_CHECK_STEPS:      cfg_shadow.check_steps      = cfg_data_i[DistW-1:0];
          REG_THRESHOLD:        cfg_shadow.threshold        = cfg_data_i[AdcW-1:0];
          REG_DEAD_SPACE_HIGH:  cfg_shadow.dead_space_high  = cfg_data_i[AdcW-1:0];
          REG_DEAD_SPACE_LOW:   cfg_shadow.dead_space_low   = cfg_data_i[AdcW-1:0];
          REG_HISTORY_LENGTH:   cfg_shadow.history_length   = cfg_data_i[3:0];
          REG_DEAD_SPACE_LIMIT: cfg_shadow.dead_space_limit = cfg_data_i[DsCntW-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        seen_beat.cmd       = cmd_i;
        seen_beat.channel   = channel_i;
        seen_beat.forward   = forward_i;
        seen_beat.adc_value = adc_value_i;
        expected_verdicts.push_back(predict_verdict(seen_beat));
        beats_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (evaluated_o === 1'b1) checks_seen++;
        if (jammed_o === 1'b1) jams_seen++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("result beat on channel %0d with nothing expected",
                                    out_channel_o));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_channel_o !== want.channel)
            report_mismatch($sformatf("out_channel %b, expected %b", out_channel_o,
                                      want.channel));
          if (evaluated_o !== want.evaluated)
            report_mismatch($sformatf("channel %0d evaluated %b, expected %b", want.channel,
                                      evaluated_o, want.evaluated));
          if (jammed_o !== want.jammed)
            report_mismatch($sformatf("channel %0d jammed %b, expected %b", want.channel,
                                      jammed_o, want.jammed));
        end
        hold = next_wait();
        if (hold != 0) begin
          out_stall_i <= 1'b1;
          stall_left = hold;
        end
      end else if (stall_left != 0) begin
        stall_left = stall_left - 1;
        if (stall_left == 0) out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STUCK_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic ch, input logic fwd,
                           input logic [AdcW-1:0] adc);
    int gap;
    gap = next_wait();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= cmd;
    channel_i   <= ch;
    forward_i   <= fwd;
    adc_value_i <= adc;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // The edge first lets the monitor log the last beat; then every result must be in.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // Bits above a register's width carry random junk, which the block must ignore.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value,
                           input int width);
    logic [CfgDataW-1:0] keep;
    keep = (24'd1 << width) - 24'd1;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= (CfgDataW'($urandom) & ~keep) | (value & keep);
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_cfg(input logic [1:0] en, input logic [DistW-1:0] steps,
                             input logic [AdcW-1:0] thr, input logic [AdcW-1:0] ds_high,
                             input logic [AdcW-1:0] ds_low, input logic [3:0] hist_len,
                             input logic [DsCntW-1:0] ds_limit);
    wait_drained();
    write_reg(REG_CHECK_STEPS, steps, DistW);
    write_reg(REG_ENABLE_MASK, CfgDataW'(en), 2);
    write_reg(REG_THRESHOLD, CfgDataW'(thr), AdcW);
    write_reg(REG_DEAD_SPACE_HIGH, CfgDataW'(ds_high), AdcW);
    write_reg(REG_DEAD_SPACE_LOW, CfgDataW'(ds_low), AdcW);
    write_reg(REG_HISTORY_LENGTH, CfgDataW'(hist_len), 4);
    write_reg(REG_DEAD_SPACE_LIMIT, CfgDataW'(ds_limit), DsCntW);
    cfg_valid_i <= 1'b0;
  endtask

  // Often readings close to the stored level, so that misses and dead-space hits build up.
  task automatic pick_level(input logic ch, output logic [AdcW-1:0] lvl);
    int r;
    int span;
    int v;
    r = $urandom_range(0, 99);
    span = int'(cfg_shadow.threshold) + 8;
    if (r < 45) begin
      v = int'(base_level[ch]) + $urandom_range(0, 2 * span) - span;
    end else if (r < 65) begin
      if ($urandom_range(0, 1)) v = $urandom_range(cfg_shadow.dead_space_high, 4095);
      else v = $urandom_range(0, cfg_shadow.dead_space_low);
    end else if (r < 75) begin
      v = $urandom_range(0, 1) ? 4095 : 0;
    end else begin
      v = $urandom_range(0, 4095);
    end
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    lvl = v[AdcW-1:0];
  endtask

  task automatic run_phase(input int budget);
    int              sent;
    int              nsteps;
    logic            ch;
    logic [AdcW-1:0] lvl;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 99) < 75) begin
        // A run of steps, mostly forward on one channel, that can reach a check distance of up to 40, then a sample.
        ch = 1'($urandom_range(0, 1));
        nsteps = (cfg_shadow.check_steps > 24'd40) ? int'($urandom_range(0, 40)) :
                 int'(cfg_shadow.check_steps) + int'($urandom_range(0, 3));
        for (int k = 0; k < nsteps; k++) begin
          if ($urandom_range(0, 15) == 0)
            send_beat(CMD_STEP, ~ch, 1'($urandom_range(0, 1)), AdcW'($urandom));
          else
            send_beat(CMD_STEP, ch, $urandom_range(0, 9) != 0, AdcW'($urandom));
          sent++;
        end
        pick_level(ch, lvl);
        send_beat(CMD_SAMPLE, ch, 1'($urandom_range(0, 1)), lvl);
      end else begin
        send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), AdcW'($urandom));
      end
      sent++;
    end
  endtask

  // Reset register values: first level capture, negative count, a zero reading left unset.
  task automatic test_reset_levels();
    send_beat(CMD_SAMPLE, 1'b0, 1'b1, 12'd2000);
    send_beat(CMD_STEP,   1'b0, 1'b0, 12'd4095);
    send_beat(CMD_SAMPLE, 1'b0, 1'b0, 12'd2100);
    send_beat(CMD_SAMPLE, 1'b1, 1'b1, 12'd0);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 12'd4095);
  endtask

  // Three misses in a row trigger; a large move clears it and a zero reading unsets the level.
  task automatic test_error_history();
    program_cfg(2'd3, 24'd1, 12'd100, 12'd4095, 12'd0, 4'd3, 8'd8);
    send_beat(CMD_STEP,   1'b1, 1'b1, 12'd0);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 12'd4095);
    send_beat(CMD_STEP,   1'b1, 1'b1, 12'd0);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 12'd4090);
    send_beat(CMD_STEP,   1'b1, 1'b1, 12'd0);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 12'd4000);
    send_beat(CMD_STEP,   1'b1, 1'b1, 12'd0);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 12'd0);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 12'd1);
  endtask

  // Empty history mask triggers on any check; a disabled channel ignores samples, not steps.
  task automatic test_disable_and_short_history();
    program_cfg(2'd1, 24'd0, 12'd0, 12'd4095, 12'd0, 4'd0, 8'd8);
    send_beat(CMD_STEP,   1'b0, 1'b1, 12'd0);
    send_beat(CMD_SAMPLE, 1'b0, 1'b0, 12'd1000);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 12'd5);
    send_beat(CMD_STEP,   1'b1, 1'b0, 12'd0);
  endtask

  // Zero dead-space limit forces a trigger; over-long history is clipped to eight.
  task automatic test_dead_space();
    program_cfg(2'd3, 24'd0, 12'd4095, 12'd100, 12'd50, 4'd15, 8'd0);
    send_beat(CMD_SAMPLE, 1'b0, 1'b0, 12'd1001);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 12'd60);
    send_beat(CMD_STEP,   1'b1, 1'b1, 12'd0);
    send_beat(CMD_SAMPLE, 1'b1, 1'b0, 12'd60);
    send_beat(CMD_SAMPLE, 1'b0, 1'b1, 12'd4095);
  endtask

  task automatic test_random_traffic();
    no_idle = 1'b0;
    program_cfg(2'd3, 24'd8, 12'd100, 12'd3800, 12'd300, 4'd3, 8'd4);
    run_phase(300);
    no_idle = 1'b1;
    program_cfg(2'd1, 24'd1, 12'd4095, 12'd4095, 12'd0, 4'd8, 8'd255);
    run_phase(250);
    no_idle = 1'b0;
    program_cfg(2'd2, 24'd0, 12'd0, 12'd4095, 12'd0, 4'd1, 8'd1);
    run_phase(250);
    program_cfg(2'd0, 24'd6, 12'd500, 12'd2048, 12'd2047, 4'd2, 8'd3);
    run_phase(60);
    program_cfg(2'd3, 24'd16777215, 12'd100, 12'd4095, 12'd0, 4'd3, 8'd8);
    run_phase(60);
    no_idle = 1'b1;
    program_cfg(2'd3, 24'd5, 12'd300, 12'd2000, 12'd2000, 4'd15, 8'd0);
    run_phase(250);
    no_idle = 1'b0;
    program_cfg(2'd3, 24'd3, 12'd50, 12'd0, 12'd4095, 4'd0, 8'd3);
    run_phase(250);
    program_cfg(2'd3, 24'd12, 12'd200, 12'd3000, 12'd1000, 4'd5, 8'd2);
    run_phase(280);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_levels();
    test_error_history();
    test_disable_and_short_history();
    test_dead_space();
    test_random_traffic();
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (expected_verdicts.size() != 0)
      report_mismatch($sformatf("%0d result beats never arrived", expected_verdicts.size()));
    $display("Run covered %0d input beats and %0d result beats over directed and random settings.",
             beats_taken, results_seen);
    $display("%0d results came from distance checks and %0d reported a jammed channel.",
             checks_seen, jams_seen);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
design/fmjd_pkg.sv
design/fmjd_eval.sv
design/filament_motion_jam_detector.sv
tb/sv/filament_motion_jam_detector_tb.sv
